>>> sv/i2cdiv_pkg.sv
// Shared types and constants for the I2C clock divider search core.
// Used by the controller, the datapath and the top level; depends on nothing.
package i2cdiv_pkg;

  localparam int CLK_W  = 20;  // source clock, target and gap width
  localparam int HALF_W = 19;  // half the source clock, also the rate width
  localparam int S_W    = 4;   // sample divider counter, holds 1..8
  localparam int T_W    = 7;   // step divider counter, holds 1..64
  localparam int P_W    = 10;  // divider product, at most 8 * 64
  localparam int CNT_W  = 5;   // quotient bit counter, holds 0..19
  localparam int SAMPLE_FIELD_W = 3;
  localparam int STEP_FIELD_W   = 6;

  localparam logic [STEP_FIELD_W-1:0] HS_STEP_MASK = 6'h07;
  localparam logic [STEP_FIELD_W-1:0] STEP_MASK    = 6'h3f;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // capture a new transaction and reset the search
    logic div_start;  // load the divider with half clock and a product
    logic div_final;  // with div_start: divide by the kept pair's product
    logic eval;       // judge the finished quotient and advance the pair
    logic out_load;   // write the result register
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic div_done;   // quotient is complete
    logic last_pair;  // current pair is the last of the search
  } dp_stat_t;

endpackage

>>> sv/i2c_clock_divider_search_core.sv
// Top level of the I2C clock divider search core.
// Instantiates i2cdiv_ctrl and i2cdiv_dp; uses i2cdiv_pkg for shared types.
//
//  Channel  | Direction | Handshake        | Payload
//  ---------+-----------+------------------+------------------------------------------
//  in_      | input     | in_valid/stall   | source_clock_khz, high_speed, target_khz
//  out_     | output    | out_valid/stall  | sample_field, step_field, achieved_khz, status
//  cfg_     | input     | cfg_valid/ready  | initial_gap_limit
//
// Each transaction tries every divider pair (512 in standard mode, 64 in
// high-speed mode), then divides once more for the kept pair's rate and loads
// the result. The search time is set by the shared restoring divider, which
// retires one quotient bit per cycle over the 19-bit half clock. Reset is
// synchronous and active low, and returns the gap limit to 13000. A new
// transaction is accepted while a finished result still waits under
// out_stall; the search only stops if it finishes again before that result is
// taken.
module i2c_clock_divider_search_core #(
  parameter int MAX_SAMPLE  = 8,
  parameter int MAX_STEP    = 64,
  parameter int MAX_HS_STEP = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [19:0] in_source_clock_khz,
  input  logic        in_high_speed,
  input  logic [19:0] in_target_khz,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_sample_field,
  output logic [5:0]  out_step_field,
  output logic [18:0] out_achieved_khz,
  output logic        out_status,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [19:0] cfg_initial_gap_limit
);

  i2cdiv_pkg::ctrl_cmd_t cmd;
  i2cdiv_pkg::dp_stat_t  stat;

  // The gap limit register always takes a write; the user must write it only while
  // the core is idle (the core does not enforce this), so no search sees it change.
  assign cfg_ready = 1'b1;

  // The controller sequences the search: for each pair it starts the divider,
  // waits for the quotient, then lets the datapath judge it and step to the
  // next pair. After the last pair the kept pair is divided once more to get
  // its achieved rate and the over-speed decision.
  i2cdiv_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  // The datapath holds the transaction, the pair counters, the best pair so
  // far, the divider and the result register.
  i2cdiv_dp #(
    .MAX_SAMPLE  (MAX_SAMPLE),
    .MAX_STEP    (MAX_STEP),
    .MAX_HS_STEP (MAX_HS_STEP)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_gap    (cfg_initial_gap_limit),
    .in_clock   (in_source_clock_khz),
    .in_hs      (in_high_speed),
    .in_target  (in_target_khz),
    .cmd        (cmd),
    .stat       (stat),
    .res_sample (out_sample_field),
    .res_step   (out_step_field),
    .res_rate   (out_achieved_khz),
    .res_status (out_status)
  );

endmodule

>>> sv/i2cdiv_ctrl.sv
// Controller state machine of the I2C clock divider search core.
// Depends on i2cdiv_pkg for the command and status structs.
module i2cdiv_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  output logic                  out_valid,
  input  logic                  out_stall,
  input  i2cdiv_pkg::dp_stat_t  stat,
  output i2cdiv_pkg::ctrl_cmd_t cmd
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_START  = 3'd1;
  localparam logic [2:0] ST_DIV    = 3'd2;
  localparam logic [2:0] ST_EVAL   = 3'd3;
  localparam logic [2:0] ST_FSTART = 3'd4;
  localparam logic [2:0] ST_FDIV   = 3'd5;
  localparam logic [2:0] ST_OUT    = 3'd6;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_START;
        end
      end
      ST_START: begin
        cmd.div_start = 1'b1;
        state_nxt     = ST_DIV;
      end
      ST_DIV: begin
        if (stat.div_done) begin
          state_nxt = ST_EVAL;
        end
      end
      ST_EVAL: begin
        cmd.eval  = 1'b1;
        state_nxt = stat.last_pair ? ST_FSTART : ST_START;
      end
      ST_FSTART: begin
        cmd.div_start = 1'b1;
        cmd.div_final = 1'b1;
        state_nxt     = ST_FDIV;
      end
      ST_FDIV: begin
        if (stat.div_done) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

>>> sv/i2cdiv_dp.sv
// Datapath of the I2C clock divider search core: pair counters, best-pair
// tracking, a one-bit-per-cycle restoring divider and the result register.
// Depends on i2cdiv_pkg for widths, masks and the command and status structs.
module i2cdiv_dp #(
  parameter int MAX_SAMPLE  = 8,
  parameter int MAX_STEP    = 64,
  parameter int MAX_HS_STEP = 8
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      cfg_we,
  input  logic [i2cdiv_pkg::CLK_W-1:0]              cfg_gap,
  input  logic [i2cdiv_pkg::CLK_W-1:0]              in_clock,
  input  logic                                      in_hs,
  input  logic [i2cdiv_pkg::CLK_W-1:0]              in_target,
  input  i2cdiv_pkg::ctrl_cmd_t                     cmd,
  output i2cdiv_pkg::dp_stat_t                      stat,
  output logic [i2cdiv_pkg::SAMPLE_FIELD_W-1:0]     res_sample,
  output logic [i2cdiv_pkg::STEP_FIELD_W-1:0]       res_step,
  output logic [i2cdiv_pkg::HALF_W-1:0]             res_rate,
  output logic                                      res_status
);

  localparam int CLK_W  = i2cdiv_pkg::CLK_W;
  localparam int HALF_W = i2cdiv_pkg::HALF_W;
  localparam int S_W    = i2cdiv_pkg::S_W;
  localparam int T_W    = i2cdiv_pkg::T_W;
  localparam int P_W    = i2cdiv_pkg::P_W;
  localparam int CNT_W  = i2cdiv_pkg::CNT_W;
  localparam int SF_W   = i2cdiv_pkg::SAMPLE_FIELD_W;
  localparam int TF_W   = i2cdiv_pkg::STEP_FIELD_W;

  localparam logic [S_W-1:0] S_MAX   = S_W'(MAX_SAMPLE);
  localparam logic [T_W-1:0] T_MAX   = T_W'(MAX_STEP);
  localparam logic [T_W-1:0] T_HSMAX = T_W'(MAX_HS_STEP);

  logic [CLK_W-1:0]  gap_limit_r;
  logic [HALF_W-1:0] half_r;
  logic [CLK_W-1:0]  target_r;
  logic              hs_r;
  logic [T_W-1:0]    limit_r;
  logic [S_W-1:0]    s_r, best_s_r;
  logic [T_W-1:0]    t_r, best_t_r;
  logic [CLK_W-1:0]  best_gap_r;
  logic [P_W-1:0]    div_d_r;
  logic [P_W-2:0]    rem_r;
  logic [HALF_W-1:0] dq_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [SF_W-1:0]   res_sample_r;
  logic [TF_W-1:0]   res_step_r;
  logic [HALF_W-1:0] res_rate_r;
  logic              res_status_r;

  logic [T_W-1:0]    in_limit;
  logic [P_W-1:0]    prod;
  logic [P_W-1:0]    trial;
  logic              ge;
  logic [P_W-1:0]    trial_sub;
  logic [CLK_W-1:0]  rate_ext;
  logic              over;
  logic [CLK_W-1:0]  gap;
  logic              better;

  assign in_limit = in_hs ? T_HSMAX : T_MAX;

  assign prod = cmd.div_final ? P_W'(best_s_r) * P_W'(best_t_r)
                              : P_W'(s_r) * P_W'(t_r);

  // Restoring division: remainder stays below the divisor, so it fits in
  // one bit less than the product width.
  assign trial     = {rem_r, dq_r[HALF_W-1]};
  assign ge        = (trial >= div_d_r);
  assign trial_sub = trial - div_d_r;

  assign rate_ext = {1'b0, dq_r};
  assign over     = (rate_ext > target_r);
  assign gap      = target_r - rate_ext;
  assign better   = !over && (gap < best_gap_r);

  assign stat.div_done  = (cnt_r == '0);
  assign stat.last_pair = (s_r == S_MAX) && (t_r == limit_r);

  assign res_sample = res_sample_r;
  assign res_step   = res_step_r;
  assign res_rate   = res_rate_r;
  assign res_status = res_status_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gap_limit_r <= CLK_W'(13000);
      cnt_r       <= '0;
    end else begin
      if (cfg_we) begin
        gap_limit_r <= cfg_gap;
      end
      if (cmd.div_start) begin
        cnt_r <= CNT_W'(HALF_W);
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      half_r     <= in_clock[CLK_W-1:1];
      target_r   <= in_target;
      hs_r       <= in_hs;
      limit_r    <= in_limit;
      s_r        <= S_W'(1);
      t_r        <= T_W'(1);
      best_s_r   <= S_MAX;
      best_t_r   <= in_limit;
      best_gap_r <= gap_limit_r;
    end
    if (cmd.div_start) begin
      div_d_r <= prod;
      rem_r   <= '0;
      dq_r    <= half_r;
    end else if (cnt_r != '0) begin
      rem_r <= ge ? trial_sub[P_W-2:0] : trial[P_W-2:0];
      dq_r  <= {dq_r[HALF_W-2:0], ge};
    end
    if (cmd.eval) begin
      if (better) begin
        best_gap_r <= gap;
        best_s_r   <= s_r;
        best_t_r   <= t_r;
      end
      if (t_r == limit_r) begin
        t_r <= T_W'(1);
        s_r <= s_r + S_W'(1);
      end else begin
        t_r <= t_r + T_W'(1);
      end
    end
    if (cmd.out_load) begin
      res_status_r <= over;
      if (over) begin
        res_sample_r <= '0;
        res_step_r   <= '0;
        res_rate_r   <= '0;
      end else begin
        res_sample_r <= SF_W'(best_s_r - S_W'(1));
        res_step_r   <= TF_W'(best_t_r - T_W'(1))
                        & (hs_r ? i2cdiv_pkg::HS_STEP_MASK : i2cdiv_pkg::STEP_MASK);
        res_rate_r   <= dq_r;
      end
    end
  end

endmodule

>>> sv/i2cdiv_chk.sv
// Port-level checker for the I2C clock divider search core.
// Bound to i2c_clock_divider_search_core; needs no package.
module i2cdiv_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [2:0]  out_sample_field,
  input logic [5:0]  out_step_field,
  input logic [18:0] out_achieved_khz,
  input logic        out_status
);

  // A result that is stalled stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // An over-speed result carries all-zero fields.
  a_over_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status |->
      (out_sample_field == 3'd0) && (out_step_field == 6'd0) &&
      (out_achieved_khz == 19'd0))
    else $error("over-speed result with nonzero fields");

  // Once a transaction is accepted the core is busy with its search.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted again right after a transaction");

  // A new result only appears at the end of a search.
  a_result_from_search: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without a search in progress");

endmodule

bind i2c_clock_divider_search_core i2cdiv_chk u_i2cdiv_chk (.*);

>>> test/i2c_clock_divider_search_core_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for i2c_clock_divider_search_core: a directed table, then random phases.
// Depends on i2cdiv_pkg for field widths and step masks, and on the core RTL itself.
module i2c_clock_divider_search_core_test;

  localparam int CLK_W          = i2cdiv_pkg::CLK_W;
  localparam int HALF_W         = i2cdiv_pkg::HALF_W;
  localparam int SAMPLE_FIELD_W = i2cdiv_pkg::SAMPLE_FIELD_W;
  localparam int STEP_FIELD_W   = i2cdiv_pkg::STEP_FIELD_W;

  localparam logic [STEP_FIELD_W-1:0] HS_STEP_MASK = i2cdiv_pkg::HS_STEP_MASK;
  localparam logic [STEP_FIELD_W-1:0] STEP_MASK    = i2cdiv_pkg::STEP_MASK;

  // Divider limits of the instance; the predictor uses the same values.
  localparam int SAMPLE_LIMIT  = 8;
  localparam int STEP_LIMIT    = 64;
  localparam int HS_STEP_LIMIT = 8;

  localparam logic [CLK_W-1:0] FIELD_MAX  = 20'hFFFFF;
  localparam logic [CLK_W-1:0] GAP_AT_RST = 20'd13000;

  localparam logic STATUS_OK         = 1'b0;
  localparam logic STATUS_OVER_SPEED = 1'b1;

  // The budget assumes every transaction runs in standard mode under the worst stalls,
  // then takes that several times over.
  localparam int CYCLE_LIMIT     = 5_000_000;
  localparam int DRAIN_CYCLES    = 12_000;
  localparam int HOLD_CYCLES     = 25_000;
  localparam int HOLD_AT_RESULT  = 30;
  localparam int RANDOM_PHASES   = 4;
  localparam int ITEMS_PER_PHASE = 21;
  localparam int MAX_REPORTS     = 10;

  typedef struct packed {
    logic [SAMPLE_FIELD_W-1:0] sample_field;
    logic [STEP_FIELD_W-1:0]   step_field;
    logic [HALF_W-1:0]         achieved_khz;
    logic                      status;
  } divider_setting_t;

  // One row of the directed table. A row with new_gap set first writes the gap limit
  // while the core is idle. Rows with typed set carry an expected result written out
  // by hand; the predictor supplies the expectation for all other rows.
  typedef struct packed {
    logic             new_gap;
    logic [CLK_W-1:0] gap_value;
    logic [CLK_W-1:0] source_khz;
    logic             high_speed;
    logic [CLK_W-1:0] target_khz;
    logic             typed;
    divider_setting_t setting;
  } directed_row_t;

  localparam int DIRECTED_ROWS = 18;

  localparam directed_row_t DIRECTED [DIRECTED_ROWS] = '{
    // Zero source clock: every rate is zero, so the first pair wins.
    '{1'b0, 20'd0, 20'd0, 1'b0, 20'd0, 1'b1,
      '{3'd0, 6'd0, 19'd0, STATUS_OK}},
    // Zero clock, but the shortfall to a maximal target never beats the limit:
    // the maximum high-speed dividers are kept.
    '{1'b0, 20'd0, 20'd0, 1'b1, FIELD_MAX, 1'b1,
      '{3'd7, 6'd7, 19'd0, STATUS_OK}},
    // Fastest clock and a zero target: even the slowest pair is too fast.
    '{1'b0, 20'd0, FIELD_MAX, 1'b0, 20'd0, 1'b1,
      '{3'd0, 6'd0, 19'd0, STATUS_OVER_SPEED}},
    '{1'b0, 20'd0, FIELD_MAX, 1'b1, 20'd0, 1'b1,
      '{3'd0, 6'd0, 19'd0, STATUS_OVER_SPEED}},
    // Fastest clock and maximal target: no pair gets within the limit, so the
    // maximum standard dividers stay, at 524287 / 512 = 1023 kHz.
    '{1'b0, 20'd0, FIELD_MAX, 1'b0, FIELD_MAX, 1'b1,
      '{3'd7, 6'd63, 19'd1023, STATUS_OK}},
    // Ordinary bus set-ups, left to the predictor.
    '{1'b0, 20'd0, 20'd100000, 1'b0, 20'd100, 1'b0, '0},
    '{1'b0, 20'd0, 20'd100000, 1'b1, 20'd3400, 1'b0, '0},
    '{1'b0, 20'd0, 20'd26000, 1'b0, 20'd400, 1'b0, '0},
    '{1'b0, 20'd0, 20'd26000, 1'b1, 20'd1000, 1'b0, '0},
    // A one kHz clock halves to zero.
    '{1'b0, 20'd0, 20'd1, 1'b1, 20'd1, 1'b1,
      '{3'd0, 6'd0, 19'd0, STATUS_OK}},
    // Gap limit of zero: nothing can beat it, so the maximum dividers are kept.
    '{1'b1, 20'd0, 20'd0, 1'b0, 20'd0, 1'b1,
      '{3'd7, 6'd63, 19'd0, STATUS_OK}},
    '{1'b0, 20'd0, 20'd200000, 1'b1, 20'd5000, 1'b0, '0},
    // Widest gap limit: the first pair now wins for the fastest clock.
    '{1'b1, FIELD_MAX, FIELD_MAX, 1'b0, FIELD_MAX, 1'b1,
      '{3'd0, 6'd0, 19'd524287, STATUS_OK}},
    // A shortfall equal to the limit does not beat it.
    '{1'b0, 20'd0, 20'd0, 1'b0, FIELD_MAX, 1'b1,
      '{3'd7, 6'd63, 19'd0, STATUS_OK}},
    '{1'b0, 20'd0, 20'd54321, 1'b1, 20'd777, 1'b0, '0},
    // Gap limit of one: only an exact match is accepted.
    '{1'b1, 20'd1, 20'd2, 1'b1, 20'd1, 1'b1,
      '{3'd0, 6'd0, 19'd1, STATUS_OK}},
    '{1'b0, 20'd0, 20'd1048574, 1'b1, 20'd524287, 1'b0, '0},
    // Back to the reset value.
    '{1'b1, GAP_AT_RST, 20'd48000, 1'b1, 20'd400, 1'b0, '0}
  };

  logic                      clk;
  logic                      rst_n;
  logic                      in_valid;
  logic                      in_stall;
  logic [CLK_W-1:0]          in_source_clock_khz;
  logic                      in_high_speed;
  logic [CLK_W-1:0]          in_target_khz;
  logic                      out_valid;
  logic                      out_stall;
  logic [SAMPLE_FIELD_W-1:0] out_sample_field;
  logic [STEP_FIELD_W-1:0]   out_step_field;
  logic [HALF_W-1:0]         out_achieved_khz;
  logic                      out_status;
  logic                      cfg_valid;
  logic                      cfg_ready;
  logic [CLK_W-1:0]          cfg_initial_gap_limit;

  // Settings still owed by the core, oldest first.
  divider_setting_t pending_settings[$];

  // Shadow of the gap limit register.
  logic [CLK_W-1:0] gap_limit_shadow;

  int fail_count;
  int items_sent;
  int results_taken;
  int gap_writes;
  int cycle_count;

  i2c_clock_divider_search_core #(
    .MAX_SAMPLE (SAMPLE_LIMIT),
    .MAX_STEP   (STEP_LIMIT),
    .MAX_HS_STEP(HS_STEP_LIMIT)
  ) dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_source_clock_khz  (in_source_clock_khz),
    .in_high_speed        (in_high_speed),
    .in_target_khz        (in_target_khz),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_sample_field     (out_sample_field),
    .out_step_field       (out_step_field),
    .out_achieved_khz     (out_achieved_khz),
    .out_status           (out_status),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_initial_gap_limit(cfg_initial_gap_limit)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Predicts the divider setting for one request. The search walks the sample divider
  // in the outer loop and the step divider in the inner loop, both upward, and keeps
  // the first pair whose shortfall strictly beats the best so far. Pairs faster than
  // the target are never kept. The maximum pair is the fallback when nothing beats
  // the gap limit, and it can still turn out too fast.
  function automatic divider_setting_t search_dividers(input logic [CLK_W-1:0] source_khz,
                                                       input logic high_speed,
                                                       input logic [CLK_W-1:0] target_khz,
                                                       input logic [CLK_W-1:0] gap_limit);
    divider_setting_t  setting;
    int unsigned       half_khz;
    int unsigned       want_khz;
    int unsigned       step_max;
    int unsigned       best_gap;
    int unsigned       best_sample;
    int unsigned       best_step;
    int unsigned       rate;
    half_khz    = 32'(source_khz[CLK_W-1:1]);
    want_khz    = 32'(target_khz);
    step_max    = high_speed ? HS_STEP_LIMIT : STEP_LIMIT;
    best_gap    = 32'(gap_limit);
    best_sample = SAMPLE_LIMIT;
    best_step   = step_max;
    for (int unsigned s = 1; s <= SAMPLE_LIMIT; s++) begin
      for (int unsigned t = 1; t <= step_max; t++) begin
        rate = half_khz / (s * t);
        if (rate <= want_khz && want_khz - rate < best_gap) begin
          best_gap    = want_khz - rate;
          best_sample = s;
          best_step   = t;
        end
      end
    end
    rate = half_khz / (best_sample * best_step);
    if (rate > want_khz) begin
      setting = '{3'd0, 6'd0, 19'd0, STATUS_OVER_SPEED};
    end else begin
      setting.sample_field = SAMPLE_FIELD_W'(best_sample - 1);
      setting.step_field   = STEP_FIELD_W'(best_step - 1) &
                             (high_speed ? HS_STEP_MASK : STEP_MASK);
      setting.achieved_khz = HALF_W'(rate);
      setting.status       = STATUS_OK;
    end
    return setting;
  endfunction

  // Counts every failure; only the first few are printed.
  task automatic note_failure(input string msg);
    fail_count++;
    if (fail_count <= MAX_REPORTS) begin
      $display("[%0t] %s", $realtime, msg);
    end
  endtask

  // Offers one request and holds it until the core takes it. The expectation is queued at
  // the accepting edge. The idle loop lowers valid only on cycles that carry no offer,
  // so back-to-back requests keep valid high without a glitch. Between the 45th and the
  // 70th request the sender never idles.
  task automatic offer_request(input logic [CLK_W-1:0] source_khz, input logic high_speed,
                               input logic [CLK_W-1:0] target_khz, input logic typed,
                               input divider_setting_t typed_setting);
    while ((items_sent < 45 || items_sent >= 70) && $urandom_range(0, 99) < 11) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid            <= 1'b1;
    in_source_clock_khz <= source_khz;
    in_high_speed       <= high_speed;
    in_target_khz       <= target_khz;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (typed) begin
      pending_settings.push_back(typed_setting);
    end else begin
      pending_settings.push_back(search_dividers(source_khz, high_speed, target_khz,
                                                 gap_limit_shadow));
    end
    items_sent++;
  endtask

  // Writes the gap limit once every owed result has come back. Each request yields
  // exactly one result, so an empty queue means the core is idle.
  task automatic write_gap_limit(input logic [CLK_W-1:0] value);
    in_valid <= 1'b0;
    while (pending_settings.size() != 0) @(posedge clk);
    cfg_valid             <= 1'b1;
    cfg_initial_gap_limit <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid        <= 1'b0;
    gap_limit_shadow  = value;
    gap_writes++;
  endtask

  // Stimulus: reset, the directed table, then random phases with their own gap limits.
  initial begin : stimulus
    logic [CLK_W-1:0] source_khz;
    logic [CLK_W-1:0] target_khz;
    logic             high_speed;
    logic [CLK_W-1:0] phase_gap;
    int unsigned      pick_sample;
    int unsigned      pick_step;
    int unsigned      near_rate;
    fail_count            = 0;
    items_sent            = 0;
    gap_writes            = 0;
    gap_limit_shadow      = GAP_AT_RST;
    rst_n                 <= 1'b0;
    in_valid              <= 1'b0;
    in_source_clock_khz   <= '0;
    in_high_speed         <= 1'b0;
    in_target_khz         <= '0;
    cfg_valid             <= 1'b0;
    cfg_initial_gap_limit <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    for (int r = 0; r < DIRECTED_ROWS; r++) begin
      if (DIRECTED[r].new_gap) begin
        write_gap_limit(DIRECTED[r].gap_value);
      end
      offer_request(DIRECTED[r].source_khz, DIRECTED[r].high_speed, DIRECTED[r].target_khz,
                    DIRECTED[r].typed, DIRECTED[r].setting);
    end

    // Each random phase runs under its own gap limit. Most requests use high-speed mode
    // because a standard-mode search tries eight times as many pairs.
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0:       phase_gap = GAP_AT_RST;
        1:       phase_gap = CLK_W'($urandom_range(0, 50000));
        2:       phase_gap = CLK_W'($urandom);
        default: phase_gap = CLK_W'($urandom_range(0, 2000));
      endcase
      write_gap_limit(phase_gap);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        high_speed = ($urandom_range(0, 99) < 75);
        source_khz = CLK_W'($urandom);
        case ($urandom_range(0, 9)) inside
          [0:3]: begin
            // Realistic set-up: aim just above the rate of some real divider pair.
            pick_sample = $urandom_range(1, SAMPLE_LIMIT);
            pick_step   = $urandom_range(1, high_speed ? HS_STEP_LIMIT : STEP_LIMIT);
            near_rate   = (source_khz >> 1) / (pick_sample * pick_step);
            target_khz  = CLK_W'(near_rate + $urandom_range(0, 40));
          end
          [4:6]: begin
            target_khz = CLK_W'($urandom);
          end
          [7:8]: begin
            // Typical bus rates, mostly within reach of a slow source clock.
            target_khz = CLK_W'($urandom_range(0, 3400));
            source_khz = CLK_W'($urandom_range(0, 200000));
          end
          default: begin
            source_khz = ($urandom_range(0, 1) != 0) ? FIELD_MAX : '0;
            target_khz = ($urandom_range(0, 1) != 0) ? FIELD_MAX : '0;
          end
        endcase
        offer_request(source_khz, high_speed, target_khz, 1'b0, '0);
      end
    end

    // Drain, then watch a while longer for any stray result.
    in_valid <= 1'b0;
    while (pending_settings.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Checked %0d transactions (%0d from the directed table) over %0d gap limit writes,",
             results_taken, DIRECTED_ROWS, gap_writes);
    $display("with random idling on both sides and one %0d-cycle output hold-off.", HOLD_CYCLES);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Result side: takes results, compares each against the oldest expectation and drives
  // out_stall. After the 30th result the receiver holds off for a long stretch while the
  // sender keeps offering, so the core fills up and has to stall its input. Results 50
  // through 74 are taken without any idling.
  initial begin : result_checker
    divider_setting_t got;
    divider_setting_t want;
    int               hold_left;
    logic             hold_done;
    results_taken = 0;
    hold_left     = 0;
    hold_done     = 1'b0;
    out_stall     <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        got = '{out_sample_field, out_step_field, out_achieved_khz, out_status};
        if (pending_settings.size() == 0) begin
          note_failure($sformatf("unexpected result sample=%0d step=%0d khz=%0d status=%0d",
                                 got.sample_field, got.step_field, got.achieved_khz,
                                 got.status));
        end else begin
          want = pending_settings.pop_front();
          if (got !== want) begin
            note_failure($sformatf({"result %0d mismatch: expected sample=%0d step=%0d ",
                                    "khz=%0d status=%0d, got sample=%0d step=%0d khz=%0d ",
                                    "status=%0d"},
                                   results_taken, want.sample_field, want.step_field,
                                   want.achieved_khz, want.status, got.sample_field,
                                   got.step_field, got.achieved_khz, got.status));
          end
        end
        results_taken++;
      end
      if (!hold_done && results_taken == HOLD_AT_RESULT) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (results_taken >= 50 && results_taken < 75) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(0, 99) < 11);
      end
    end
  end

  // Watchdog: a hung handshake or a missing result ends the run here.
  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timeout after %0d cycles with %0d results still owed", cycle_count,
             pending_settings.size());
    $display("Some tests failed");
    $finish;
  end

endmodule
